// ===== src/static_box_collision_shift_top_defines.svh =====
// assertion macros shared by the collision shift rtl
`ifndef STATIC_BOX_COLLISION_SHIFT_TOP_DEFINES_SVH
`define STATIC_BOX_COLLISION_SHIFT_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SBCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sbcs_pkg.sv =====
// shared types and constants for the static box collision shift block
package sbcs_pkg;

   localparam int PUSH_BITS      = 26;
   localparam int BOX_BITS       = 16;
   localparam int RADIUS_BITS    = 15;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic signed [PUSH_BITS-1:0] PUSH_MAX = {1'b0, {(PUSH_BITS-1){1'b1}}};
   localparam logic signed [PUSH_BITS-1:0] PUSH_MIN = {1'b1, {(PUSH_BITS-1){1'b0}}};

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROBE_X      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROBE_Y      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROBE_Z      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROBE_RADIUS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROBE_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEADING      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PREVIOUS_X   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PREVIOUS_Z   = 3'd7;

   typedef enum logic [1:0] {
      SIDE_NONE  = 2'd0,
      SIDE_FRONT = 2'd1,
      SIDE_LEFT  = 2'd2,
      SIDE_RIGHT = 2'd3
   } side_type;

   typedef enum logic [1:0] {
      FACING_NORTH = 2'd0,
      FACING_WEST  = 2'd1,
      FACING_SOUTH = 2'd2,
      FACING_EAST  = 2'd3
   } facing_type;

   typedef enum logic [1:0] {
      HEADING_NORTH = 2'd0,
      HEADING_EAST  = 2'd1,
      HEADING_SOUTH = 2'd2,
      HEADING_WEST  = 2'd3
   } heading_type;

endpackage

// ===== src/sbcs_req_if.sv =====
// mesh instance channel
interface sbcs_req_if #(
   parameter int COORD_BITS = 25
);
   import sbcs_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] mesh_x;
   logic signed [COORD_BITS-1:0] mesh_y;
   logic signed [COORD_BITS-1:0] mesh_z;
   logic [1:0]                   mesh_facing;
   logic signed [BOX_BITS-1:0]   box_x_low;
   logic signed [BOX_BITS-1:0]   box_x_high;
   logic signed [BOX_BITS-1:0]   box_y_low;
   logic signed [BOX_BITS-1:0]   box_y_high;
   logic signed [BOX_BITS-1:0]   box_z_low;
   logic signed [BOX_BITS-1:0]   box_z_high;
   logic                         non_solid;
   logic                         last_mesh;

   modport source (
      output valid, mesh_x, mesh_y, mesh_z, mesh_facing, box_x_low, box_x_high,
             box_y_low, box_y_high, box_z_low, box_z_high, non_solid, last_mesh,
      input  ready
   );

   modport sink (
      input  valid, mesh_x, mesh_y, mesh_z, mesh_facing, box_x_low, box_x_high,
             box_y_low, box_y_high, box_z_low, box_z_high, non_solid, last_mesh,
      output ready
   );

endinterface

// ===== src/sbcs_rsp_if.sv =====
// collision result channel
interface sbcs_rsp_if;
   import sbcs_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        hit;
   side_type                    side;
   logic signed [PUSH_BITS-1:0] push_x;
   logic signed [PUSH_BITS-1:0] push_z;

   modport source (
      output valid, hit, side, push_x, push_z,
      input  ready
   );

   modport sink (
      input  valid, hit, side, push_x, push_z,
      output ready
   );

endinterface

// ===== src/sbcs_bounds.sv =====
// stage that turns the local box by the mesh facing and places it in world space
module sbcs_bounds #(
   parameter int COORD_BITS = 25
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [COORD_BITS-1:0]           mesh_x,
   input  logic signed [COORD_BITS-1:0]           mesh_y,
   input  logic signed [COORD_BITS-1:0]           mesh_z,
   input  logic [1:0]                             mesh_facing,
   input  logic signed [sbcs_pkg::BOX_BITS-1:0]   box_x_low,
   input  logic signed [sbcs_pkg::BOX_BITS-1:0]   box_x_high,
   input  logic signed [sbcs_pkg::BOX_BITS-1:0]   box_y_low,
   input  logic signed [sbcs_pkg::BOX_BITS-1:0]   box_y_high,
   input  logic signed [sbcs_pkg::BOX_BITS-1:0]   box_z_low,
   input  logic signed [sbcs_pkg::BOX_BITS-1:0]   box_z_high,
   input  logic                                   non_solid,
   input  logic                                   last_mesh,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [COORD_BITS:0]             x_min,
   output logic signed [COORD_BITS:0]             x_max,
   output logic signed [COORD_BITS:0]             y_min,
   output logic signed [COORD_BITS:0]             y_max,
   output logic signed [COORD_BITS:0]             z_min,
   output logic signed [COORD_BITS:0]             z_max,
   output logic                                   out_solid,
   output logic                                   out_last
);
   import sbcs_pkg::*;

   localparam int BW = COORD_BITS + 1;

   logic signed [BW-1:0] mx, my, mz;
   logic signed [BW-1:0] bxl, bxh, byl, byh, bzl, bzh;
   logic signed [BW-1:0] x_min_in, x_max_in, z_min_in, z_max_in;
   logic                 valid_ff, valid_in;
   logic signed [BW-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff, z_min_ff, z_max_ff;
   logic                 solid_ff, last_ff;

   // widen operands
   assign mx  = BW'(mesh_x);
   assign my  = BW'(mesh_y);
   assign mz  = BW'(mesh_z);
   assign bxl = BW'(box_x_low);
   assign bxh = BW'(box_x_high);
   assign byl = BW'(box_y_low);
   assign byh = BW'(box_y_high);
   assign bzl = BW'(box_z_low);
   assign bzh = BW'(box_z_high);

   // quarter-turn of the local box
   always_comb begin
      case (facing_type'(mesh_facing))
         FACING_WEST: begin
            x_min_in = mx - bzh;
            x_max_in = mx - bzl;
            z_min_in = mz + bxl;
            z_max_in = mz + bxh;
         end
         FACING_SOUTH: begin
            x_min_in = mx - bxh;
            x_max_in = mx - bxl;
            z_min_in = mz - bzh;
            z_max_in = mz - bzl;
         end
         FACING_EAST: begin
            x_min_in = mx + bzl;
            x_max_in = mx + bzh;
            z_min_in = mz - bxh;
            z_max_in = mz - bxl;
         end
         default: begin
            x_min_in = mx + bxl;
            x_max_in = mx + bxh;
            z_min_in = mz + bzl;
            z_max_in = mz + bzh;
         end
      endcase
   end

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // bounds register
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_min_ff <= x_min_in;
         x_max_ff <= x_max_in;
         y_min_ff <= my + byl;
         y_max_ff <= my + byh;
         z_min_ff <= z_min_in;
         z_max_ff <= z_max_in;
         solid_ff <= !non_solid;
         last_ff  <= last_mesh;
      end
   end

   assign out_valid = valid_ff;
   assign x_min     = x_min_ff;
   assign x_max     = x_max_ff;
   assign y_min     = y_min_ff;
   assign y_max     = y_max_ff;
   assign z_min     = z_min_ff;
   assign z_max     = z_max_ff;
   assign out_solid = solid_ff;
   assign out_last  = last_ff;

endmodule

// ===== src/sbcs_overlap.sv =====
// stage that tests strict overlap against the probe box and forms the push-out distances
`include "static_box_collision_shift_top_defines.svh"
module sbcs_overlap #(
   parameter int COORD_BITS = 25
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic signed [COORD_BITS-1:0]            probe_x,
   input  logic signed [COORD_BITS-1:0]            probe_y,
   input  logic signed [COORD_BITS-1:0]            probe_z,
   input  logic [sbcs_pkg::RADIUS_BITS-1:0]        probe_radius,
   input  logic [sbcs_pkg::RADIUS_BITS-1:0]        probe_height,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [COORD_BITS:0]              x_min,
   input  logic signed [COORD_BITS:0]              x_max,
   input  logic signed [COORD_BITS:0]              y_min,
   input  logic signed [COORD_BITS:0]              y_max,
   input  logic signed [COORD_BITS:0]              z_min,
   input  logic signed [COORD_BITS:0]              z_max,
   input  logic                                    in_solid,
   input  logic                                    in_last,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic signed [COORD_BITS+1:0]            lo_x,
   output logic signed [COORD_BITS+1:0]            hi_x,
   output logic signed [COORD_BITS+1:0]            lo_z,
   output logic signed [COORD_BITS+1:0]            hi_z,
   output logic                                    out_hit,
   output logic                                    out_last
);
   import sbcs_pkg::*;

   localparam int BW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 2;

   logic signed [BW-1:0] px, py, pz, r, h;
   logic signed [BW-1:0] rx_min, rx_max, ry_min, rz_min, rz_max;
   logic                 overlap;
   logic                 valid_ff, valid_in;
   logic signed [DW-1:0] lo_x_ff, hi_x_ff, lo_z_ff, hi_z_ff;
   logic                 hit_ff, last_ff;

   // probe box from the query registers
   assign px     = BW'(probe_x);
   assign py     = BW'(probe_y);
   assign pz     = BW'(probe_z);
   assign r      = BW'(probe_radius);
   assign h      = BW'(probe_height);
   assign rx_min = px - r;
   assign rx_max = px + r;
   assign ry_min = py - h;
   assign rz_min = pz - r;
   assign rz_max = pz + r;

   // strict overlap on all three axes
   assign overlap = !(rx_max <= x_min || rx_min >= x_max || py <= y_min ||
                      ry_min >= y_max || rz_max <= z_min || rz_min >= z_max);

   // stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // penetration depths toward each face
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         lo_x_ff <= DW'(rx_max) - DW'(x_min);
         hi_x_ff <= DW'(x_max) - DW'(rx_min);
         lo_z_ff <= DW'(rz_max) - DW'(z_min);
         hi_z_ff <= DW'(z_max) - DW'(rz_min);
         hit_ff  <= in_solid && overlap;
         last_ff <= in_last;
      end
   end

   assign out_valid = valid_ff;
   assign lo_x      = lo_x_ff;
   assign hi_x      = hi_x_ff;
   assign lo_z      = lo_z_ff;
   assign hi_z      = hi_z_ff;
   assign out_hit   = hit_ff;
   assign out_last  = last_ff;

   // an overlapping mesh always has positive depth on both sides of x and z
   `SBCS_ASSERT_NOW(a_depth_positive, clock, reset, valid_ff && hit_ff,
      lo_x_ff > 0 && hi_x_ff > 0 && lo_z_ff > 0 && hi_z_ff > 0,
      "overlap reported with non-positive depth")

endmodule

// ===== src/sbcs_resolve.sv =====
// stage that picks the shifts and side, tracks the query and holds the result word
`include "static_box_collision_shift_top_defines.svh"
module sbcs_resolve #(
   parameter int COORD_BITS = 25
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic signed [COORD_BITS-1:0]            probe_x,
   input  logic signed [COORD_BITS-1:0]            probe_z,
   input  logic [sbcs_pkg::RADIUS_BITS-1:0]        probe_radius,
   input  logic [1:0]                              heading_quadrant,
   input  logic signed [COORD_BITS-1:0]            previous_x,
   input  logic signed [COORD_BITS-1:0]            previous_z,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [COORD_BITS+1:0]            lo_x,
   input  logic signed [COORD_BITS+1:0]            hi_x,
   input  logic signed [COORD_BITS+1:0]            lo_z,
   input  logic signed [COORD_BITS+1:0]            hi_z,
   input  logic                                    in_hit,
   input  logic                                    in_last,
   sbcs_rsp_if.source                              rsp_if
);
   import sbcs_pkg::*;

   localparam int DW = COORD_BITS + 2;
   localparam int SW = (DW > PUSH_BITS) ? DW : PUSH_BITS;

   logic signed [DW-1:0]        xs, zs, r, back_x, back_z;
   logic signed [DW-1:0]        shift_x, shift_z;
   logic signed [SW-1:0]        ext_x, ext_z;
   logic signed [PUSH_BITS-1:0] sat_x, sat_z;
   logic                        x_wide, z_wide, along_z;
   side_type                    side_in;
   logic                        emit, fire;
   logic                        query_done_ff, query_done_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        hit_ff;
   side_type                    side_ff;
   logic signed [PUSH_BITS-1:0] push_x_ff, push_z_ff;

   // smaller push-out per axis
   assign xs     = (lo_x < hi_x) ? -lo_x : hi_x;
   assign zs     = (lo_z < hi_z) ? -lo_z : hi_z;
   assign r      = DW'(probe_radius);
   assign back_x = DW'(previous_x) - DW'(probe_x);
   assign back_z = DW'(previous_z) - DW'(probe_z);
   assign x_wide = (xs > r) || (xs < -r);
   assign z_wide = (zs > r) || (zs < -r);
   assign along_z = (heading_type'(heading_quadrant) == HEADING_NORTH) ||
                    (heading_type'(heading_quadrant) == HEADING_SOUTH);

   // side and shifts by heading quadrant
   always_comb begin
      if (along_z) begin
         if (x_wide) begin
            shift_x = back_x;
            shift_z = zs;
            side_in = SIDE_FRONT;
         end else begin
            shift_x = xs;
            shift_z = '0;
            side_in = ((xs > 0) == (heading_type'(heading_quadrant) == HEADING_NORTH)) ?
                      SIDE_LEFT : SIDE_RIGHT;
         end
      end else begin
         if (z_wide) begin
            shift_x = xs;
            shift_z = back_z;
            side_in = SIDE_FRONT;
         end else begin
            shift_x = '0;
            shift_z = zs;
            side_in = ((zs > 0) == (heading_type'(heading_quadrant) == HEADING_WEST)) ?
                      SIDE_LEFT : SIDE_RIGHT;
         end
      end
   end

   // saturate to the push field
   assign ext_x = SW'(shift_x);
   assign ext_z = SW'(shift_z);
   always_comb begin
      if ((&ext_x[SW-1:PUSH_BITS-1]) || !(|ext_x[SW-1:PUSH_BITS-1])) begin
         sat_x = ext_x[PUSH_BITS-1:0];
      end else begin
         sat_x = ext_x[SW-1] ? PUSH_MIN : PUSH_MAX;
      end
      if ((&ext_z[SW-1:PUSH_BITS-1]) || !(|ext_z[SW-1:PUSH_BITS-1])) begin
         sat_z = ext_z[PUSH_BITS-1:0];
      end else begin
         sat_z = ext_z[SW-1] ? PUSH_MIN : PUSH_MAX;
      end
   end

   // a word leaves only for the first hit or a miss at the last mesh
   assign emit     = !query_done_ff && (in_hit || in_last);
   assign in_ready = !emit || !rsp_valid_ff || rsp_if.ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      query_done_in = query_done_ff;
      if (fire) begin
         if (query_done_ff) begin
            query_done_in = !in_last;
         end else begin
            query_done_in = in_hit && !in_last;
         end
      end
   end

   always_comb begin
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         query_done_ff <= query_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         hit_ff <= in_hit;
         if (in_hit) begin
            side_ff   <= side_in;
            push_x_ff <= sat_x;
            push_z_ff <= sat_z;
         end else begin
            side_ff   <= SIDE_NONE;
            push_x_ff <= '0;
            push_z_ff <= '0;
         end
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.hit    = hit_ff;
   assign rsp_if.side   = side_ff;
   assign rsp_if.push_x = push_x_ff;
   assign rsp_if.push_z = push_z_ff;

   `SBCS_ASSERT_NOW(a_miss_is_clear, clock, reset, rsp_valid_ff && !hit_ff,
      side_ff == SIDE_NONE && push_x_ff == '0 && push_z_ff == '0,
      "miss word carries a side or a shift")

   `SBCS_ASSERT_NOW(a_side_shift_pair, clock, reset,
      rsp_valid_ff && hit_ff && side_ff != SIDE_FRONT,
      side_ff != SIDE_NONE && ((push_x_ff == '0) != (push_z_ff == '0)),
      "side hit must shift along exactly one axis")

   `SBCS_ASSERT_NEXT(a_hit_closes_query, clock, reset,
      fire && !query_done_ff && in_hit && !in_last,
      query_done_ff && rsp_valid_ff && hit_ff,
      "first hit did not report and close the query")

endmodule

// ===== src/static_box_collision_shift_top.sv =====
// top level of the static box collision shift block
//
//   channel   dir   handshake         word
//   req_if    in    valid / ready     one static mesh instance
//   rsp_if    out   valid / ready     hit, side, push_x, push_z
//   csr_*     in    csr_we            probe setup and heading registers
//
// one mesh word is taken per cycle while the result register is not held by a
// stalled output; the accepting edge loads the input register, and the word then
// passes the box placement, overlap test and result registers in that order
// each stage has its own valid bit, so bubbles close up while the output stalls
// and words that give no result pass a stalled output register
// reset is synchronous and clears all valid bits, the query state and the configuration registers
module static_box_collision_shift_top #(
   parameter int COORD_BITS = 25
) (
   input  logic                                  clock,
   input  logic                                  reset,
   sbcs_req_if.sink                              req_if,
   sbcs_rsp_if.source                            rsp_if,
   input  logic                                  csr_we,
   input  logic [sbcs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wdata
);
   import sbcs_pkg::*;

   logic signed [COORD_BITS-1:0]  probe_x_ff, probe_y_ff, probe_z_ff;
   logic signed [COORD_BITS-1:0]  previous_x_ff, previous_z_ff;
   logic [RADIUS_BITS-1:0]        probe_radius_ff, probe_height_ff;
   logic [1:0]                    heading_ff;

   logic                          in_valid_ff, in_valid_in;
   logic signed [COORD_BITS-1:0]  mesh_x_ff, mesh_y_ff, mesh_z_ff;
   logic [1:0]                    mesh_facing_ff;
   logic signed [BOX_BITS-1:0]    box_x_low_ff, box_x_high_ff, box_y_low_ff;
   logic signed [BOX_BITS-1:0]    box_y_high_ff, box_z_low_ff, box_z_high_ff;
   logic                          non_solid_ff, last_mesh_ff;

   logic                          bnd_ready, bnd_valid, ovl_ready, ovl_valid, res_ready;
   logic signed [COORD_BITS:0]    x_min, x_max, y_min, y_max, z_min, z_max;
   logic                          bnd_solid, bnd_last, ovl_hit, ovl_last;
   logic signed [COORD_BITS+1:0]  lo_x, hi_x, lo_z, hi_z;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_x_ff      <= '0;
         probe_y_ff      <= '0;
         probe_z_ff      <= '0;
         probe_radius_ff <= '0;
         probe_height_ff <= '0;
         heading_ff      <= '0;
         previous_x_ff   <= '0;
         previous_z_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROBE_X:      probe_x_ff      <= csr_wdata;
            CSR_PROBE_Y:      probe_y_ff      <= csr_wdata;
            CSR_PROBE_Z:      probe_z_ff      <= csr_wdata;
            CSR_PROBE_RADIUS: probe_radius_ff <= csr_wdata[RADIUS_BITS-1:0];
            CSR_PROBE_HEIGHT: probe_height_ff <= csr_wdata[RADIUS_BITS-1:0];
            CSR_HEADING:      heading_ff      <= csr_wdata[1:0];
            CSR_PREVIOUS_X:   previous_x_ff   <= csr_wdata;
            CSR_PREVIOUS_Z:   previous_z_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register
   assign req_if.ready = !in_valid_ff || bnd_ready;
   assign in_valid_in  = req_if.ready ? req_if.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         mesh_x_ff      <= req_if.mesh_x;
         mesh_y_ff      <= req_if.mesh_y;
         mesh_z_ff      <= req_if.mesh_z;
         mesh_facing_ff <= req_if.mesh_facing;
         box_x_low_ff   <= req_if.box_x_low;
         box_x_high_ff  <= req_if.box_x_high;
         box_y_low_ff   <= req_if.box_y_low;
         box_y_high_ff  <= req_if.box_y_high;
         box_z_low_ff   <= req_if.box_z_low;
         box_z_high_ff  <= req_if.box_z_high;
         non_solid_ff   <= req_if.non_solid;
         last_mesh_ff   <= req_if.last_mesh;
      end
   end

   // box placement
   sbcs_bounds #(
      .COORD_BITS (COORD_BITS)
   ) u_bounds (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid_ff),
      .in_ready    (bnd_ready),
      .mesh_x      (mesh_x_ff),
      .mesh_y      (mesh_y_ff),
      .mesh_z      (mesh_z_ff),
      .mesh_facing (mesh_facing_ff),
      .box_x_low   (box_x_low_ff),
      .box_x_high  (box_x_high_ff),
      .box_y_low   (box_y_low_ff),
      .box_y_high  (box_y_high_ff),
      .box_z_low   (box_z_low_ff),
      .box_z_high  (box_z_high_ff),
      .non_solid   (non_solid_ff),
      .last_mesh   (last_mesh_ff),
      .out_valid   (bnd_valid),
      .out_ready   (ovl_ready),
      .x_min       (x_min),
      .x_max       (x_max),
      .y_min       (y_min),
      .y_max       (y_max),
      .z_min       (z_min),
      .z_max       (z_max),
      .out_solid   (bnd_solid),
      .out_last    (bnd_last)
   );

   // overlap test
   sbcs_overlap #(
      .COORD_BITS (COORD_BITS)
   ) u_overlap (
      .clock        (clock),
      .reset        (reset),
      .probe_x      (probe_x_ff),
      .probe_y      (probe_y_ff),
      .probe_z      (probe_z_ff),
      .probe_radius (probe_radius_ff),
      .probe_height (probe_height_ff),
      .in_valid     (bnd_valid),
      .in_ready     (ovl_ready),
      .x_min        (x_min),
      .x_max        (x_max),
      .y_min        (y_min),
      .y_max        (y_max),
      .z_min        (z_min),
      .z_max        (z_max),
      .in_solid     (bnd_solid),
      .in_last      (bnd_last),
      .out_valid    (ovl_valid),
      .out_ready    (res_ready),
      .lo_x         (lo_x),
      .hi_x         (hi_x),
      .lo_z         (lo_z),
      .hi_z         (hi_z),
      .out_hit      (ovl_hit),
      .out_last     (ovl_last)
   );

   // shift selection and result word
   sbcs_resolve #(
      .COORD_BITS (COORD_BITS)
   ) u_resolve (
      .clock            (clock),
      .reset            (reset),
      .probe_x          (probe_x_ff),
      .probe_z          (probe_z_ff),
      .probe_radius     (probe_radius_ff),
      .heading_quadrant (heading_ff),
      .previous_x       (previous_x_ff),
      .previous_z       (previous_z_ff),
      .in_valid         (ovl_valid),
      .in_ready         (res_ready),
      .lo_x             (lo_x),
      .hi_x             (hi_x),
      .lo_z             (lo_z),
      .hi_z             (hi_z),
      .in_hit           (ovl_hit),
      .in_last          (ovl_last),
      .rsp_if           (rsp_if)
   );

endmodule

// ===== bench/tb_static_box_collision_shift_top.sv =====
// testbench for the static box collision shift block: directed and random mesh streams
`timescale 1ns / 100ps

module tb_static_box_collision_shift_top;
   import sbcs_pkg::*;

   localparam int COORD_BITS   = 25;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));

   // one mesh instance word
   typedef struct {
      logic signed [COORD_BITS-1:0] mesh_x;
      logic signed [COORD_BITS-1:0] mesh_y;
      logic signed [COORD_BITS-1:0] mesh_z;
      facing_type                   mesh_facing;
      logic signed [BOX_BITS-1:0]   box_x_low;
      logic signed [BOX_BITS-1:0]   box_x_high;
      logic signed [BOX_BITS-1:0]   box_y_low;
      logic signed [BOX_BITS-1:0]   box_y_high;
      logic signed [BOX_BITS-1:0]   box_z_low;
      logic signed [BOX_BITS-1:0]   box_z_high;
      logic                         non_solid;
      logic                         last_mesh;
   } mesh_word_type;

   // one collision result word
   typedef struct {
      logic                        hit;
      side_type                    side;
      logic signed [PUSH_BITS-1:0] push_x;
      logic signed [PUSH_BITS-1:0] push_z;
   } collision_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_we;
   logic [CSR_INDEX_BITS-1:0]    csr_index;
   logic [COORD_BITS-1:0]        csr_wdata;

   sbcs_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   sbcs_rsp_if                            rsp_if ();

   static_box_collision_shift_top #(.COORD_BITS(COORD_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the probe registers and the query state
   logic signed [COORD_BITS-1:0] probe_x_q, probe_y_q, probe_z_q;
   logic signed [COORD_BITS-1:0] previous_x_q, previous_z_q;
   logic [RADIUS_BITS-1:0]       radius_q, height_q;
   heading_type                  heading_q;
   logic                         query_done_q;

   collision_type expected_results[$];
   int mismatches, words_sent, hits_seen, misses_seen, probe_setups;
   int send_idle_pct, recv_stall_pct;
   int hold_requests, hold_served, hold_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic signed [PUSH_BITS-1:0] clamp_push(input longint v);
      if (v > longint'(PUSH_MAX)) return PUSH_MAX;
      if (v < longint'(PUSH_MIN)) return PUSH_MIN;
      return v[PUSH_BITS-1:0];
   endfunction

   // works out the result of one mesh word, returns 1 when a word is due
   function automatic bit predict_collision(input mesh_word_type m,
                                            output collision_type res);
      longint mx, my, mz, xl, xh, yl, yh, zl, zh;
      longint px, py, pz, r, h;
      longint xmin, xmax, zmin, zmax, ymin, ymax;
      longint a, b, xs, zs, shx, shz;
      side_type side;
      res = '{1'b0, SIDE_NONE, '0, '0};
      if (query_done_q) begin
         if (m.last_mesh) query_done_q = 1'b0;
         return 1'b0;
      end
      if (!m.non_solid) begin
         mx = m.mesh_x;   my = m.mesh_y;   mz = m.mesh_z;
         xl = m.box_x_low; xh = m.box_x_high;
         yl = m.box_y_low; yh = m.box_y_high;
         zl = m.box_z_low; zh = m.box_z_high;
         px = probe_x_q;  py = probe_y_q;  pz = probe_z_q;
         r = longint'(radius_q);
         h = longint'(height_q);
         ymin = my + yl;
         ymax = my + yh;
         // turn the local box by its quarter-turn facing
         case (m.mesh_facing)
            FACING_WEST: begin
               xmin = mx - zh; xmax = mx - zl; zmin = mz + xl; zmax = mz + xh;
            end
            FACING_SOUTH: begin
               xmin = mx - xh; xmax = mx - xl; zmin = mz - zh; zmax = mz - zl;
            end
            FACING_EAST: begin
               xmin = mx + zl; xmax = mx + zh; zmin = mz - xh; zmax = mz - xl;
            end
            default: begin
               xmin = mx + xl; xmax = mx + xh; zmin = mz + zl; zmax = mz + zh;
            end
         endcase
         // strict overlap on all three axes
         if (px + r > xmin && px - r < xmax && py > ymin && py - h < ymax &&
             pz + r > zmin && pz - r < zmax) begin
            a = px + r - xmin; b = xmax - (px - r);
            xs = (a < b) ? -a : b;
            a = pz + r - zmin; b = zmax - (pz - r);
            zs = (a < b) ? -a : b;
            if (heading_q == HEADING_NORTH || heading_q == HEADING_SOUTH) begin
               if (xs > r || xs < -r) begin
                  shx = longint'(previous_x_q) - px; shz = zs; side = SIDE_FRONT;
               end else begin
                  shx = xs; shz = 0;
                  side = ((xs > 0) == (heading_q == HEADING_NORTH)) ? SIDE_LEFT : SIDE_RIGHT;
               end
            end else begin
               if (zs > r || zs < -r) begin
                  shx = xs; shz = longint'(previous_z_q) - pz; side = SIDE_FRONT;
               end else begin
                  shx = 0; shz = zs;
                  side = ((zs > 0) == (heading_q == HEADING_WEST)) ? SIDE_LEFT : SIDE_RIGHT;
               end
            end
            res.hit    = 1'b1;
            res.side   = side;
            res.push_x = clamp_push(shx);
            res.push_z = clamp_push(shz);
            query_done_q = !m.last_mesh;
            return 1'b1;
         end
      end
      // a query that ends without a hit reports a miss
      return m.last_mesh;
   endfunction

   // predict at every accepted mesh word
   always @(posedge clock) begin : predict_results
      mesh_word_type m;
      collision_type res;
      if (!reset && req_if.valid && req_if.ready) begin
         m.mesh_x      = req_if.mesh_x;
         m.mesh_y      = req_if.mesh_y;
         m.mesh_z      = req_if.mesh_z;
         m.mesh_facing = facing_type'(req_if.mesh_facing);
         m.box_x_low   = req_if.box_x_low;
         m.box_x_high  = req_if.box_x_high;
         m.box_y_low   = req_if.box_y_low;
         m.box_y_high  = req_if.box_y_high;
         m.box_z_low   = req_if.box_z_low;
         m.box_z_high  = req_if.box_z_high;
         m.non_solid   = req_if.non_solid;
         m.last_mesh   = req_if.last_mesh;
         if (predict_collision(m, res)) expected_results.push_back(res);
      end
   end

   // compare every accepted result word with the oldest prediction
   always @(posedge clock) begin : check_results
      collision_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_error("result word arrived with nothing expected");
         end else begin
            want = expected_results.pop_front();
            if (want.hit) hits_seen++;
            else misses_seen++;
            if (rsp_if.hit !== want.hit)
               report_error($sformatf("hit mismatch: expected %0d, got %0d",
                                      want.hit, rsp_if.hit));
            if (rsp_if.side !== want.side)
               report_error($sformatf("side mismatch: expected %0d, got %0d",
                                      want.side, rsp_if.side));
            if (rsp_if.push_x !== want.push_x)
               report_error($sformatf("push_x mismatch: expected %0d, got %0d",
                                      want.push_x, rsp_if.push_x));
            if (rsp_if.push_z !== want.push_z)
               report_error($sformatf("push_z mismatch: expected %0d, got %0d",
                                      want.push_z, rsp_if.push_z));
         end
      end
   end

   // result side: random stalls plus requested long hold-offs
   initial begin
      rsp_if.ready <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // run limit
   initial begin
      #4_000_000;
      $display("tb_static_box_collision_shift_top: FAIL");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [COORD_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_PROBE_X:      probe_x_q    = data;
         CSR_PROBE_Y:      probe_y_q    = data;
         CSR_PROBE_Z:      probe_z_q    = data;
         CSR_PROBE_RADIUS: radius_q     = data[RADIUS_BITS-1:0];
         CSR_PROBE_HEIGHT: height_q     = data[RADIUS_BITS-1:0];
         CSR_HEADING:      heading_q    = heading_type'(data[1:0]);
         CSR_PREVIOUS_X:   previous_x_q = data;
         CSR_PREVIOUS_Z:   previous_z_q = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // narrow registers get junk in the unused upper bits
   task automatic set_probe(input longint px, input longint py, input longint pz,
                            input int r, input int h, input heading_type hd,
                            input longint ox, input longint oz);
      write_reg(CSR_PROBE_X, px[COORD_BITS-1:0]);
      write_reg(CSR_PROBE_Y, py[COORD_BITS-1:0]);
      write_reg(CSR_PROBE_Z, pz[COORD_BITS-1:0]);
      write_reg(CSR_PROBE_RADIUS, {10'($urandom), r[RADIUS_BITS-1:0]});
      write_reg(CSR_PROBE_HEIGHT, {10'($urandom), h[RADIUS_BITS-1:0]});
      write_reg(CSR_HEADING, {23'($urandom), 2'(hd)});
      write_reg(CSR_PREVIOUS_X, ox[COORD_BITS-1:0]);
      write_reg(CSR_PREVIOUS_Z, oz[COORD_BITS-1:0]);
      probe_setups++;
   endtask

   task automatic randomize_probe(input heading_type hd);
      set_probe(longint'($signed(25'($urandom))), longint'($signed(25'($urandom))),
                longint'($signed(25'($urandom))), $urandom_range(0, 4000),
                $urandom_range(0, 4000), hd, longint'($signed(25'($urandom))),
                longint'($signed(25'($urandom))));
   endtask

   task automatic send_mesh(input mesh_word_type m);
      if (send_idle_pct != 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid       <= 1'b1;
      req_if.mesh_x      <= m.mesh_x;
      req_if.mesh_y      <= m.mesh_y;
      req_if.mesh_z      <= m.mesh_z;
      req_if.mesh_facing <= m.mesh_facing;
      req_if.box_x_low   <= m.box_x_low;
      req_if.box_x_high  <= m.box_x_high;
      req_if.box_y_low   <= m.box_y_low;
      req_if.box_y_high  <= m.box_y_high;
      req_if.box_z_low   <= m.box_z_low;
      req_if.box_z_high  <= m.box_z_high;
      req_if.non_solid   <= m.non_solid;
      req_if.last_mesh   <= m.last_mesh;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   // block goes idle: no result owed and the pipeline flushed
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic mesh_word_type make_mesh(input longint x, input longint y,
                                               input longint z, input facing_type f,
                                               input int xl, input int xh, input int yl,
                                               input int yh, input int zl, input int zh,
                                               input bit ns, input bit last);
      mesh_word_type m;
      m.mesh_x = x[COORD_BITS-1:0];
      m.mesh_y = y[COORD_BITS-1:0];
      m.mesh_z = z[COORD_BITS-1:0];
      m.mesh_facing = f;
      m.box_x_low  = xl[BOX_BITS-1:0]; m.box_x_high = xh[BOX_BITS-1:0];
      m.box_y_low  = yl[BOX_BITS-1:0]; m.box_y_high = yh[BOX_BITS-1:0];
      m.box_z_low  = zl[BOX_BITS-1:0]; m.box_z_high = zh[BOX_BITS-1:0];
      m.non_solid = ns;
      m.last_mesh = last;
      return m;
   endfunction

   function automatic longint jitter(input int w);
      return longint'($urandom_range(0, 2 * w)) - w;
   endfunction

   // mesh placed around the probe so that hits and misses both come up
   function automatic mesh_word_type near_probe_mesh(input bit last);
      int span, rh, xl, xh, t;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 3000);
      rh = int'(height_q) / 2;
      xl = -int'($urandom_range(0, span));
      xh = $urandom_range(0, span);
      // now and then an inverted box
      if ($urandom_range(0, 19) == 0) begin
         t = xl; xl = xh; xh = t;
      end
      return make_mesh(longint'(probe_x_q) + jitter(int'(radius_q) + span),
                       longint'(probe_y_q) - rh + jitter(rh + span),
                       longint'(probe_z_q) + jitter(int'(radius_q) + span),
                       facing_type'($urandom_range(0, 3)), xl, xh,
                       -int'($urandom_range(0, span)), $urandom_range(0, span),
                       -int'($urandom_range(0, span)), $urandom_range(0, span),
                       1'b0, last);
   endfunction

   function automatic mesh_word_type noise_mesh(input bit last);
      mesh_word_type m;
      m.mesh_x = COORD_BITS'($urandom);
      m.mesh_y = COORD_BITS'($urandom);
      m.mesh_z = COORD_BITS'($urandom);
      m.mesh_facing = facing_type'($urandom_range(0, 3));
      m.box_x_low = BOX_BITS'($urandom);  m.box_x_high = BOX_BITS'($urandom);
      m.box_y_low = BOX_BITS'($urandom);  m.box_y_high = BOX_BITS'($urandom);
      m.box_z_low = BOX_BITS'($urandom);  m.box_z_high = BOX_BITS'($urandom);
      m.non_solid = 1'($urandom_range(0, 1));
      m.last_mesh = last;
      return m;
   endfunction

   // queries of one to six meshes with some noise and non-solid words mixed in
   task automatic run_queries(input int n_items);
      int sent, len, k, roll;
      mesh_word_type m;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 6);
         for (k = 0; k < len; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) m = noise_mesh(k == len - 1);
            else m = near_probe_mesh(k == len - 1);
            if (roll >= 8 && roll < 16) m.non_solid = 1'b1;
            send_mesh(m);
            sent++;
         end
      end
   endtask

   // reset register values: point probe at the origin
   task automatic test_reset_defaults();
      send_mesh(make_mesh(0, 0, 0, FACING_NORTH, -1, 1, -1, 1, -1, 1, 1'b0, 1'b1));
      send_mesh(make_mesh(5, 0, 0, FACING_NORTH, -1, 1, -1, 1, -1, 1, 1'b0, 1'b1));
      send_mesh(make_mesh(0, 0, 0, FACING_NORTH, -1, 1, -1, 1, -1, 1, 1'b1, 1'b1));
      wait_idle();
   endtask

   // first hit ends the query, misses, non-solid and inverted boxes, left and right
   task automatic test_query_rules();
      set_probe(1000, 500, -1000, 200, 300, HEADING_NORTH, 900, -1200);
      send_mesh(make_mesh(1000, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 0));
      send_mesh(make_mesh(1000, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 0));
      send_mesh(make_mesh(9000, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 1));
      send_mesh(make_mesh(1000, 400, -1000, FACING_NORTH, 50, -50, -50, 50, -50, 50, 0, 1));
      send_mesh(make_mesh(1000, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 1, 0));
      send_mesh(make_mesh(1000, 400, -1000, FACING_SOUTH, -50, 50, -50, 50, -50, 50, 0, 1));
      send_mesh(make_mesh(1240, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 1));
      send_mesh(make_mesh(760, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 1));
      send_mesh(make_mesh(1000, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 0));
      send_mesh(make_mesh(1000, 400, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 1));
      send_mesh(make_mesh(1000, 9000, -1000, FACING_NORTH, -50, 50, -50, 50, -50, 50, 0, 1));
      wait_idle();
   endtask

   // asymmetric box under every facing
   task automatic test_facings();
      int f;
      set_probe(1000, 500, -1000, 200, 300, HEADING_EAST, 1300, -700);
      for (f = 0; f < 4; f++)
         send_mesh(make_mesh(1100, 400, -900, facing_type'(f),
                             -150, 20, -100, 100, -30, 250, 0, 1));
      wait_idle();
   endtask

   // coordinate and box extremes, widest frontal push-back
   task automatic test_extremes();
      set_probe(COORD_MAX, COORD_MAX, COORD_MIN, 32767, 32767, HEADING_NORTH,
                COORD_MIN, COORD_MAX);
      send_mesh(make_mesh(COORD_MAX, COORD_MAX, COORD_MIN, FACING_NORTH,
                          -32768, 32767, -32768, 32767, -32768, 32767, 0, 1));
      send_mesh(make_mesh(COORD_MIN, COORD_MIN, COORD_MAX, FACING_SOUTH,
                          -32768, 32767, -32768, 32767, -32768, 32767, 0, 1));
      wait_idle();
      set_probe(COORD_MIN, COORD_MIN, COORD_MIN, 32767, 32767, HEADING_WEST,
                COORD_MAX, COORD_MAX);
      send_mesh(make_mesh(COORD_MIN, COORD_MIN, COORD_MIN, FACING_EAST,
                          -32768, 32767, -32768, 32767, -32768, 32767, 0, 1));
      send_mesh(make_mesh(COORD_MIN, COORD_MIN + 20, COORD_MIN, FACING_WEST,
                          -32768, 32767, -32768, 32767, -32768, 32767, 0, 1));
      wait_idle();
   endtask

   // one phase per idling pattern, one heading per phase
   task automatic test_idle_phases();
      int phase;
      int send_pct[4] = '{0, 70, 0, 36};
      int recv_pct[4] = '{0, 0, 70, 36};
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pct[phase];
         recv_stall_pct <= recv_pct[phase];
         randomize_probe(heading_type'(phase));
         run_queries(300);
         wait_idle();
      end
   endtask

   // short runs under fresh random probe setups
   task automatic test_config_sweep();
      int round;
      send_idle_pct = 36;
      recv_stall_pct <= 36;
      for (round = 0; round < 4; round++) begin
         randomize_probe(heading_type'($urandom_range(0, 3)));
         run_queries(45);
         wait_idle();
      end
   endtask

   // long output hold-off while every mesh owes a result
   task automatic test_backpressure();
      int k;
      mesh_word_type m;
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      randomize_probe(heading_type'($urandom_range(0, 3)));
      hold_requests <= hold_requests + 1;
      for (k = 0; k < 60; k++) begin
         m = near_probe_mesh(1'b1);
         send_mesh(m);
      end
      wait_idle();
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_PROBE_X;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.mesh_x      <= '0;
      req_if.mesh_y      <= '0;
      req_if.mesh_z      <= '0;
      req_if.mesh_facing <= FACING_NORTH;
      req_if.box_x_low   <= '0;
      req_if.box_x_high  <= '0;
      req_if.box_y_low   <= '0;
      req_if.box_y_high  <= '0;
      req_if.box_z_low   <= '0;
      req_if.box_z_high  <= '0;
      req_if.non_solid   <= 1'b0;
      req_if.last_mesh   <= 1'b0;
      probe_x_q = '0; probe_y_q = '0; probe_z_q = '0;
      previous_x_q = '0; previous_z_q = '0;
      radius_q = '0; height_q = '0;
      heading_q = HEADING_NORTH;
      query_done_q = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      hold_requests  <= 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_query_rules();
      test_facings();
      test_extremes();
      test_idle_phases();
      test_config_sweep();
      test_backpressure();

      $display("run covered %0d mesh words under %0d probe setups", words_sent, probe_setups);
      $display("checked %0d hit and %0d miss results, %0d mismatches",
               hits_seen, misses_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb_static_box_collision_shift_top: PASS");
      end else begin
         $display("tb_static_box_collision_shift_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/sbcs_pkg.sv
src/sbcs_req_if.sv
src/sbcs_rsp_if.sv
src/sbcs_bounds.sv
src/sbcs_overlap.sv
src/sbcs_resolve.sv
src/static_box_collision_shift_top.sv
bench/tb_static_box_collision_shift_top.sv
